/* rtl/midpoint_line_rasterizer_unit_assert.svh */
// assertion macros for the midpoint line rasterizer
// used by the top level only; expects clk and rst_n in scope
`ifndef MIDPOINT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define MLR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("midpoint line rasterizer check failed");

`define MLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("midpoint line rasterizer check failed");

`else

`define MLR_ASSERT_SAME(lbl, ante, cons)

`define MLR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/mlr_pkg.sv */
// shared types and constants for the midpoint line rasterizer
// no dependencies
package mlr_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_BITS     = 24;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // shallow: x is the major axis, steep: y is the major axis
  typedef enum logic [1:0] {
    MODE_SHALLOW_UP   = 2'd0,
    MODE_STEEP_UP     = 2'd1,
    MODE_SHALLOW_DOWN = 2'd2,
    MODE_STEEP_DOWN   = 2'd3
  } mode_t;

endpackage

/* rtl/mlr_setup.sv */
// line setup: endpoint ordering, deltas, octant choice and initial decision term
// depends on mlr_pkg
module mlr_setup #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]        xa,
  input  logic [COORD_BITS-1:0]        ya,
  input  logic [COORD_BITS-1:0]        xb,
  input  logic [COORD_BITS-1:0]        yb,
  output logic [COORD_BITS-1:0]        x0,
  output logic [COORD_BITS-1:0]        y0,
  output logic [COORD_BITS-1:0]        x1,
  output logic [COORD_BITS-1:0]        y1,
  output logic [COORD_BITS:0]          dx,
  output logic signed [COORD_BITS:0]   dy,
  output mlr_pkg::mode_t               mode,
  output logic signed [COORD_BITS+2:0] dec
);
  import mlr_pkg::*;

  localparam int DW = COORD_BITS + 3;

  logic                 swap;
  logic signed [DW-1:0] dx_w;
  logic signed [DW-1:0] dy_w;

  always_comb begin
    // equal columns swap too
    swap = !(xb > xa);
    x0   = swap ? xb : xa;
    y0   = swap ? yb : ya;
    x1   = swap ? xa : xb;
    y1   = swap ? ya : yb;
    dx   = {1'b0, x1} - {1'b0, x0};
    dy   = $signed({1'b0, y1}) - $signed({1'b0, y0});
    dx_w = $signed({2'b00, dx});
    dy_w = $signed({{2{dy[COORD_BITS]}}, dy});
    if (dy_w >= 0 && dy_w <= dx_w) begin
      mode = MODE_SHALLOW_UP;
      dec  = (dy_w <<< 1) - dx_w;
    end else if (dy_w > dx_w) begin
      mode = MODE_STEEP_UP;
      dec  = dy_w - (dx_w <<< 1);
    end else if (dy_w >= -dx_w) begin
      mode = MODE_SHALLOW_DOWN;
      dec  = (dy_w <<< 1) + dx_w;
    end else begin
      mode = MODE_STEEP_DOWN;
      dec  = dy_w + (dx_w <<< 1);
    end
  end

endmodule

/* rtl/mlr_step.sv */
// one rasterizer step: end test, next pixel and next decision term
// depends on mlr_pkg
module mlr_step #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]        cur_x,
  input  logic [COORD_BITS-1:0]        cur_y,
  input  logic [COORD_BITS-1:0]        stop_x,
  input  logic [COORD_BITS-1:0]        stop_y,
  input  logic [COORD_BITS:0]          dx,
  input  logic signed [COORD_BITS:0]   dy,
  input  mlr_pkg::mode_t               mode,
  input  logic signed [COORD_BITS+2:0] dec,
  output logic [COORD_BITS-1:0]        nxt_x,
  output logic [COORD_BITS-1:0]        nxt_y,
  output logic signed [COORD_BITS+2:0] nxt_dec,
  output logic                         last
);
  import mlr_pkg::*;

  localparam int DW = COORD_BITS + 3;
  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic signed [DW-1:0] two_dx;
  logic signed [DW-1:0] two_dy;

  always_comb begin
    two_dx  = $signed({1'b0, dx, 1'b0});
    two_dy  = $signed({dy[COORD_BITS], dy, 1'b0});
    nxt_x   = cur_x;
    nxt_y   = cur_y;
    nxt_dec = dec;
    case (mode)
      MODE_SHALLOW_UP: begin
        last  = (cur_x == stop_x);
        nxt_x = cur_x + ONE;
        if (dec > 0) begin
          nxt_y   = cur_y + ONE;
          nxt_dec = dec + two_dy - two_dx;
        end else begin
          nxt_dec = dec + two_dy;
        end
      end
      MODE_STEEP_UP: begin
        last  = (cur_y == stop_y);
        nxt_y = cur_y + ONE;
        if (dec < 0) begin
          nxt_x   = cur_x + ONE;
          nxt_dec = dec + two_dy - two_dx;
        end else begin
          nxt_dec = dec - two_dx;
        end
      end
      MODE_SHALLOW_DOWN: begin
        last  = (cur_x == stop_x);
        nxt_x = cur_x + ONE;
        if (dec < 0) begin
          nxt_y   = cur_y - ONE;
          nxt_dec = dec + two_dy + two_dx;
        end else begin
          nxt_dec = dec + two_dy;
        end
      end
      default: begin
        last  = (cur_y == stop_y);
        nxt_y = cur_y - ONE;
        if (dec > 0) begin
          nxt_x   = cur_x + ONE;
          nxt_dec = dec + two_dy + two_dx;
        end else begin
          nxt_dec = dec + two_dx;
        end
      end
    endcase
  end

endmodule

/* rtl/midpoint_line_rasterizer_unit.sv */
// top level of the midpoint line rasterizer: input register, line state, result register
// depends on mlr_pkg, mlr_setup, mlr_step and midpoint_line_rasterizer_unit_assert.svh
//
// Takes one transaction per clock cycle while the output is not stalled. A load transaction
// sets up a new line (dropping any active one) and gives no pixel; each step transaction
// gives the next pixel of the active line, or nothing once its last pixel has gone out.
// A transaction is held in the input register, then the line setup or the add-and-compare
// step logic updates the line state and fills the result register, so the pixel of a step
// goes through the input register and then the result register to the output. out_stall
// reaches in_stall combinationally through the input register's advance condition.
`include "midpoint_line_rasterizer_unit_assert.svh"

module midpoint_line_rasterizer_unit #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [COORD_BITS-1:0]          in_x_start,
  input  logic [COORD_BITS-1:0]          in_y_start,
  input  logic [COORD_BITS-1:0]          in_x_end,
  input  logic [COORD_BITS-1:0]          in_y_end,
  input  logic [mlr_pkg::COLOR_BITS-1:0] in_line_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          out_pixel_x,
  output logic [COORD_BITS-1:0]          out_pixel_y,
  output logic [mlr_pkg::COLOR_BITS-1:0] out_pixel_color,
  output logic                           out_last_pixel
);
  import mlr_pkg::*;

  localparam int DW = COORD_BITS + 3;

  // input register
  logic                  s0_valid_r;
  cmd_t                  s0_cmd_r;
  logic [COORD_BITS-1:0] s0_xa_r, s0_ya_r, s0_xb_r, s0_yb_r;
  logic [COLOR_BITS-1:0] s0_color_r;

  // line state
  logic                   busy_r;
  logic [COORD_BITS-1:0]  cur_x_r, cur_y_r, stop_x_r, stop_y_r;
  logic [COORD_BITS:0]    dx_r;
  logic signed [COORD_BITS:0] dy_r;
  logic signed [DW-1:0]   dec_r;
  mode_t                  mode_r;
  logic [COLOR_BITS-1:0]  color_r;

  // result register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_last_r;

  logic advance;
  logic in_take;
  logic emit;

  logic [COORD_BITS-1:0]      su_x0, su_y0, su_x1, su_y1;
  logic [COORD_BITS:0]        su_dx;
  logic signed [COORD_BITS:0] su_dy;
  mode_t                      su_mode;
  logic signed [DW-1:0]       su_dec;

  logic [COORD_BITS-1:0] st_x, st_y;
  logic signed [DW-1:0]  st_dec;
  logic                  st_last;

  mlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .xa   (s0_xa_r),
    .ya   (s0_ya_r),
    .xb   (s0_xb_r),
    .yb   (s0_yb_r),
    .x0   (su_x0),
    .y0   (su_y0),
    .x1   (su_x1),
    .y1   (su_y1),
    .dx   (su_dx),
    .dy   (su_dy),
    .mode (su_mode),
    .dec  (su_dec)
  );

  mlr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_x   (cur_x_r),
    .cur_y   (cur_y_r),
    .stop_x  (stop_x_r),
    .stop_y  (stop_y_r),
    .dx      (dx_r),
    .dy      (dy_r),
    .mode    (mode_r),
    .dec     (dec_r),
    .nxt_x   (st_x),
    .nxt_y   (st_y),
    .nxt_dec (st_dec),
    .last    (st_last)
  );

  always_comb begin
    advance  = s0_valid_r && (!out_valid_r || !out_stall);
    in_stall = s0_valid_r && !advance;
    in_take  = in_valid && !in_stall;
    emit     = advance && (s0_cmd_r == CMD_STEP) && busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end

      if (advance && s0_cmd_r == CMD_LOAD) begin
        busy_r <= 1'b1;
      end else if (emit && st_last) begin
        busy_r <= 1'b0;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_take) begin
      s0_cmd_r   <= cmd_t'(in_command);
      s0_xa_r    <= in_x_start;
      s0_ya_r    <= in_y_start;
      s0_xb_r    <= in_x_end;
      s0_yb_r    <= in_y_end;
      s0_color_r <= in_line_color;
    end

    if (advance && s0_cmd_r == CMD_LOAD) begin
      cur_x_r  <= su_x0;
      cur_y_r  <= su_y0;
      stop_x_r <= su_x1;
      stop_y_r <= su_y1;
      dx_r     <= su_dx;
      dy_r     <= su_dy;
      mode_r   <= su_mode;
      dec_r    <= su_dec;
      color_r  <= s0_color_r;
    end else if (emit && !st_last) begin
      cur_x_r <= st_x;
      cur_y_r <= st_y;
      dec_r   <= st_dec;
    end

    if (emit) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_color_r <= color_r;
      out_last_r  <= st_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_last_r;

  // the final pixel ends the line
  `MLR_ASSERT_NEXT(a_last_ends_line, emit && st_last, !busy_r)
  // a load always leaves an active line
  `MLR_ASSERT_NEXT(a_load_arms_line, advance && s0_cmd_r == CMD_LOAD, busy_r)
  // a transaction that gives no pixel leaves the result register empty
  `MLR_ASSERT_NEXT(a_no_phantom_pixel, advance && !emit, !out_valid)
  // the input side stalls only while its register holds a transaction
  `MLR_ASSERT_SAME(a_stall_needs_item, in_stall, s0_valid_r && out_valid_r)

endmodule
